// File: sv/mfbd_pkg.sv
// Shared constants for the monochrome frame-store draw engine.
// Screen geometry, derived widths and command codes.
// No dependencies.
package mfbd_pkg;

	localparam int SCREEN_COLUMNS = 640;
	localparam int SCREEN_LINES   = 400;
	localparam int LINE_BYTES     = (SCREEN_COLUMNS + 7) / 8;
	localparam int STORE_BYTES    = LINE_BYTES * SCREEN_LINES;

	localparam int ACT_W   = 3;
	localparam int COORD_W = 11;
	localparam int ROW_W   = 16;
	localparam int BADDR_W = 15;
	localparam int DATA_W  = 8;

	// column and line index widths
	localparam int COL_W  = $clog2(SCREEN_COLUMNS);
	localparam int LINE_W = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1;
	// byte address, with headroom for the step past the last written byte
	localparam int ADDR_W = $clog2(STORE_BYTES + LINE_BYTES + 4);
	localparam int CNT_W  = $clog2(STORE_BYTES + 1);

	localparam logic [ACT_W-1:0] ACT_READ  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PIXEL = 3'd1;
	localparam logic [ACT_W-1:0] ACT_VLINE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SET   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLR   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_BLIT  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_WIPE  = 3'd6;

endpackage

// File: sv/mono_framebuffer_draw_engine_unit.sv
// Monochrome frame-store draw engine: command sequencer, address unit and
// single-port frame store.
// Depends on mfbd_pkg.
//
// Usage
//  Command channel: a command transfers at a rising edge with start high and
//  busy low. busy stays high until the command's result has been produced.
//  Result channel: strobe is high for exactly one cycle with read_data and
//  rejected; the receiver cannot hold it off.
//  Sequence after the command transfer:
//   rejected command or vertical line wholly off screen : strobed from idle
//   read byte, pixel (read-modify-write)                : address, read, use
//   vertical line / span of N bytes                     : address, N byte writes
//   blit row                                            : address, 4 byte writes
//   clear store                                         : address, STORE_BYTES writes
//  One frame-store port is shared by every access and one multiply-add
//  forms each start address; the store takes one byte per cycle.
//  After reset the sequencer is idle and the store contents are undefined
//  until a clear-store command has been run.
module mono_framebuffer_draw_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [mfbd_pkg::ACT_W-1:0]           action,
	input  logic signed [mfbd_pkg::COORD_W-1:0]  x_start,
	input  logic signed [mfbd_pkg::COORD_W-1:0]  x_end,
	input  logic signed [mfbd_pkg::COORD_W-1:0]  y_start,
	input  logic signed [mfbd_pkg::COORD_W-1:0]  y_end,
	input  logic [mfbd_pkg::ROW_W-1:0]           row_bits,
	input  logic [mfbd_pkg::BADDR_W-1:0]         byte_address,
	output logic                                 strobe,
	output logic [mfbd_pkg::DATA_W-1:0]          read_data,
	output logic                                 rejected
);
	import mfbd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADDR = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_USE  = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;

	localparam logic signed [COORD_W:0] COLS_S     = (COORD_W+1)'(SCREEN_COLUMNS);
	localparam logic signed [COORD_W:0] LINES_S    = (COORD_W+1)'(SCREEN_LINES);
	localparam logic signed [COORD_W:0] LAST_S     = (COORD_W+1)'(SCREEN_LINES - 1);
	localparam logic [ADDR_W-1:0]       LB_A       = ADDR_W'(LINE_BYTES);
	localparam logic [ADDR_W-1:0]       STORE_A    = ADDR_W'(STORE_BYTES);
	localparam logic [BADDR_W:0]        STORE_B    = (BADDR_W+1)'(STORE_BYTES);
	localparam logic [CNT_W-1:0]        STORE_C    = CNT_W'(STORE_BYTES);

	logic [2:0]            state_q;
	logic [ACT_W-1:0]      act_q;
	logic [LINE_W-1:0]     line_q;
	logic [ADDR_W-1:0]     off_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [CNT_W-1:0]      count_q;
	logic [31:0]           pat_q;
	logic                  first_q;
	logic                  strobe_q;
	logic                  rej_q;
	logic [DATA_W-1:0]     rdout_q;

	logic [DATA_W-1:0]     mem [STORE_BYTES];
	logic [DATA_W-1:0]     rdata_q;
	logic                  mem_we;
	logic [DATA_W-1:0]     mem_wdata;
	logic [DATA_W-1:0]     run_byte;
	logic                  run_last;

	// command decode
	logic                  xs_ok, ys_ok, span_ok;
	logic signed [COORD_W-1:0] lo, hi;
	logic signed [COORD_W:0]   lo_c, hi_c;
	logic [DATA_W-1:0]     bit_pat, first_m, last_m;
	logic [31:0]           blit_w;
	logic                  dec_rej, dec_none;
	logic [LINE_W-1:0]     dec_line;
	logic [ADDR_W-1:0]     dec_off;
	logic [CNT_W-1:0]      dec_cnt;
	logic [31:0]           dec_pat;

	always_comb begin
		xs_ok   = (x_start >= 0) && (COLS_S > x_start);
		ys_ok   = (y_start >= 0) && (LINES_S > y_start);
		span_ok = ys_ok && (x_start >= 0) && (COLS_S > x_end) && (x_start <= x_end);
		lo      = (y_start > y_end) ? y_end : y_start;
		hi      = (y_start > y_end) ? y_start : y_end;
		lo_c    = (lo < 0) ? '0 : (COORD_W+1)'(lo);
		hi_c    = (hi > LAST_S) ? LAST_S : (COORD_W+1)'(hi);
		bit_pat = 8'h80 >> x_start[2:0];
		first_m = 8'hFF >> x_start[2:0];
		last_m  = ~(8'h7F >> x_end[2:0]);
		blit_w  = {row_bits, 16'h0000} >> x_start[3:0];

		dec_rej  = 1'b0;
		dec_none = 1'b0;
		dec_line = y_start[LINE_W-1:0];
		dec_off  = ADDR_W'(x_start[COL_W-1:3]);
		dec_cnt  = CNT_W'(1);
		dec_pat  = {bit_pat, 24'h000000};
		case (action)
			ACT_READ: begin
				dec_rej  = ({1'b0, byte_address} >= STORE_B);
				dec_line = '0;
				dec_off  = ADDR_W'(byte_address);
			end
			ACT_PIXEL: begin
				dec_rej = !(xs_ok && ys_ok);
			end
			ACT_VLINE: begin
				dec_rej  = !xs_ok;
				dec_none = (lo_c > hi_c);
				dec_line = lo_c[LINE_W-1:0];
				dec_cnt  = CNT_W'(hi_c - lo_c + (COORD_W+1)'(1));
			end
			ACT_SET, ACT_CLR: begin
				dec_rej = !span_ok;
				dec_cnt = CNT_W'(x_end[COL_W-1:3]) - CNT_W'(x_start[COL_W-1:3]) + CNT_W'(1);
				dec_pat = (action == ACT_SET) ? {first_m, last_m, 16'h0000} : '0;
			end
			ACT_BLIT: begin
				dec_rej = !(xs_ok && ys_ok);
				dec_off = ADDR_W'(x_start[COL_W-1:3]) & ~ADDR_W'(1);
				dec_cnt = CNT_W'(4);
				dec_pat = blit_w;
			end
			ACT_WIPE: begin
				dec_line = '0;
				dec_off  = '0;
				dec_cnt  = STORE_C;
				dec_pat  = '0;
			end
			default: dec_rej = 1'b1;
		endcase
	end

	// byte written in the run loop, and the frame-store write enable and write data
	always_comb begin
		run_last = (count_q == CNT_W'(1));
		if (act_q == ACT_SET) begin
			if (first_q && run_last) run_byte = pat_q[31:24] & pat_q[23:16];
			else if (first_q)        run_byte = pat_q[31:24];
			else if (run_last)       run_byte = pat_q[23:16];
			else                     run_byte = 8'hFF;
		end else begin
			run_byte = pat_q[31:24];
		end
		mem_we    = ((state_q == ST_RUN) && (addr_q < STORE_A)) ||
		            ((state_q == ST_USE) && (act_q == ACT_PIXEL));
		mem_wdata = (state_q == ST_USE) ? (rdata_q | pat_q[31:24]) : run_byte;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			rej_q    <= 1'b0;
			rdout_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (dec_rej || dec_none) begin
							strobe_q <= 1'b1;
							rej_q    <= dec_rej;
							rdout_q  <= '0;
						end else begin
							state_q <= ST_ADDR;
						end
					end
				end
				ST_ADDR: begin
					state_q <= ((act_q == ACT_READ) || (act_q == ACT_PIXEL)) ? ST_RD : ST_RUN;
				end
				ST_RD: begin
					state_q <= ST_USE;
				end
				ST_USE: begin
					state_q  <= ST_IDLE;
					strobe_q <= 1'b1;
					rej_q    <= 1'b0;
					rdout_q  <= (act_q == ACT_READ) ? rdata_q : '0;
				end
				ST_RUN: begin
					if (run_last) begin
						state_q  <= ST_IDLE;
						strobe_q <= 1'b1;
						rej_q    <= 1'b0;
						rdout_q  <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q   <= action;
				line_q  <= dec_line;
				off_q   <= dec_off;
				count_q <= dec_cnt;
				pat_q   <= dec_pat;
				first_q <= 1'b1;
			end
			ST_ADDR: begin
				addr_q <= ADDR_W'(line_q * LB_A) + off_q;
			end
			ST_RUN: begin
				addr_q  <= addr_q + ((act_q == ACT_VLINE) ? LB_A : ADDR_W'(1));
				count_q <= count_q - CNT_W'(1);
				first_q <= 1'b0;
				if (act_q == ACT_BLIT) begin
					pat_q <= {pat_q[23:0], 8'h00};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign rejected  = rej_q;
	assign read_data = rdout_q;

endmodule
